@@ sv/eqsc_pkg.sv @@
// eqsc_pkg: request/result structs, op and status codes for the egress queue.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package eqsc_pkg;
  localparam logic [2:0] OP_OPEN = 3'd0;
  localparam logic [2:0] OP_ENQ  = 3'd1;
  localparam logic [2:0] OP_DEQ  = 3'd2;
  localparam logic [2:0] OP_OUTC = 3'd3;
  localparam logic [2:0] OP_CLOSE = 3'd4;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_CLOSING   = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_BAD_ARG   = 3'd4;
  localparam logic [2:0] ST_EMPTY     = 3'd5;
  localparam logic [2:0] ST_NO_SLOT   = 3'd6;

  localparam logic [7:0] STRIKE_MAX   = 8'd255;
  localparam logic [7:0] FAIL_STRIKES = 8'd4;
  localparam logic [7:0] OK_RELIEF    = 8'd1;
  localparam int unsigned DESC_W = 33;

  typedef struct packed {
    logic [2:0]  op;
    logic [2:0]  slot;
    logic        coalescible;
    logic        frame_type;
    logic [15:0] msg_len;
    logic [15:0] handle;
    logic        send_ok;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [2:0]  slot_out;
    logic [15:0] out_handle;
    logic [15:0] out_len;
    logic        out_type;
    logic        request_close;
    logic        freed_valid;
    logic [15:0] freed_handle;
    logic        last;
  } res_t;
endpackage
`default_nettype wire

@@ sv/eqsc_ram.sv @@
// eqsc_ram: generic single-port-write, single-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module eqsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ sv/egress_queue_with_snapshot_coalescing_top.sv @@
// Top level of the egress queue with snapshot coalescing.
// Depends on eqsc_pkg and eqsc_ram (ring, snapshot memories).
//
//  channel | ports                   | dir | moves
//  in      | in_valid/in_ready/in_req  | in  | one request
//  out     | out_valid/out_ready/out_res | out | one result
//  cfg     | cfg_valid/cfg_ready/cfg_data | in | strike_limit
//
// Each request passes a read step (memories return ring head and snapshot
// entries in the cycle after the address), then an execute step that writes
// back and loads the result register, then an output step that presents the
// result and waits on out_ready; no new request is taken until it is accepted.
// Close drains one stored handle per cycle while out_ready is high, through
// the ring memory read port, up to RING_DEPTH+1 results. Reset is synchronous
// and clears per-slot control flags; ring and snapshot memories need no clear.
`timescale 1ns / 1ps
`default_nettype none
module egress_queue_with_snapshot_coalescing_top #(
  parameter int NUM_SLOTS  = 8,
  parameter int RING_DEPTH = 8,
  parameter int STAMP_BITS = 32
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire eqsc_pkg::req_t  in_req,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output eqsc_pkg::res_t       out_res,
  input  wire logic            cfg_valid,
  output logic                 cfg_ready,
  input  wire logic [7:0]      cfg_data
);
  import eqsc_pkg::*;

  localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int RW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CW = $clog2(RING_DEPTH + 1);
  localparam int RD = NUM_SLOTS * RING_DEPTH;
  localparam int RDEP = (RD > 1) ? RD : 2;
  localparam int SDEP = (NUM_SLOTS > 1) ? NUM_SLOTS : 2;
  localparam int SAW = $clog2(SDEP);
  localparam int RAW = $clog2(RDEP);
  localparam int EW = DESC_W + STAMP_BITS;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_OUT = 2'd3;

  logic [1:0] state_r, state_nxt;
  req_t req_r;
  logic [7:0] limit_r;
  logic [NUM_SLOTS-1:0] used_r, closing_r, snap_pend_r;
  logic [7:0] strike_r [NUM_SLOTS];
  logic [RW-1:0] head_r [NUM_SLOTS];
  logic [CW-1:0] count_r [NUM_SLOTS];
  logic [STAMP_BITS-1:0] gstamp_r;
  res_t res_r;
  logic out_valid_r;
  logic [CW-1:0] drain_i_r;
  logic drain_snap_r;
  logic [15:0] snap_h_r;

  // ring and snapshot memories: {stamp, desc}
  logic ring_we, snap_we;
  logic [RAW-1:0] ring_waddr, ring_raddr;
  logic [SAW-1:0] snap_waddr;
  logic [EW-1:0] ring_wdata, ring_rdata, snap_wdata, snap_rdata;

  eqsc_ram #(.WIDTH(EW), .DEPTH(RDEP)) u_ring (
    .clk, .we(ring_we), .waddr(ring_waddr), .wdata(ring_wdata),
    .raddr(ring_raddr), .rdata(ring_rdata));
  eqsc_ram #(.WIDTH(EW), .DEPTH(SDEP)) u_snap (
    .clk, .we(snap_we), .waddr(snap_waddr), .wdata(snap_wdata),
    .raddr(SAW'(in_req.slot)), .rdata(snap_rdata));

  logic [SW-1:0] si;
  logic valid_slot;
  assign si = SW'(req_r.slot);
  assign valid_slot = (32'(req_r.slot) < NUM_SLOTS) && used_r[si];

  function automatic logic [RAW-1:0] raddr_of(input logic [SW-1:0] s,
                                              input logic [RW-1:0] idx);
    raddr_of = RAW'(32'(s) * RING_DEPTH + 32'(idx));
  endfunction

  // head slot index for the incoming request (read address in IDLE)
  logic [SW-1:0] in_si;
  assign in_si = SW'(in_req.slot);

  // tail and next stamp
  logic [RW-1:0] tail;
  logic [STAMP_BITS-1:0] stamp_inc;
  assign tail = RW'((32'(head_r[si]) + 32'(count_r[si])) % RING_DEPTH);
  assign stamp_inc = gstamp_r + 1'b1;

  logic [STAMP_BITS-1:0] sdiff;
  logic ring_older;
  assign sdiff = ring_rdata[EW-1:DESC_W] - snap_rdata[EW-1:DESC_W];
  assign ring_older = sdiff[STAMP_BITS-1];

  // open search
  logic found;
  logic [SW-1:0] free_i;
  always_comb begin
    found = 1'b0;
    free_i = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        found = 1'b1;
        free_i = SW'(i);
      end
    end
  end

  // drain index within ring
  logic [RW-1:0] drain_idx;
  assign drain_idx = RW'((32'(head_r[si]) + 32'(drain_i_r)) % RING_DEPTH);

  logic [NUM_SLOTS-1:0] used_nxt, closing_nxt, snap_pend_nxt;
  logic [7:0] strike_nxt [NUM_SLOTS];
  logic [RW-1:0] head_nxt [NUM_SLOTS];
  logic [CW-1:0] count_nxt [NUM_SLOTS];
  logic [STAMP_BITS-1:0] gstamp_nxt;
  res_t res_nxt;
  logic out_valid_nxt;
  logic [CW-1:0] drain_i_nxt;
  logic drain_snap_nxt;
  logic [15:0] snap_h_nxt;
  logic [7:0] sc, sc_new;
  logic [8:0] sum;

  assign in_ready = (state_r == S_IDLE) && !out_valid_r;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_res = res_r;

  always_comb begin
    state_nxt = state_r;
    used_nxt = used_r;
    closing_nxt = closing_r;
    snap_pend_nxt = snap_pend_r;
    strike_nxt = strike_r;
    head_nxt = head_r;
    count_nxt = count_r;
    gstamp_nxt = gstamp_r;
    res_nxt = res_r;
    out_valid_nxt = out_valid_r;
    drain_i_nxt = drain_i_r;
    drain_snap_nxt = drain_snap_r;
    snap_h_nxt = snap_h_r;
    ring_we = 1'b0;
    snap_we = 1'b0;
    ring_waddr = raddr_of(si, tail);
    snap_waddr = SAW'(si);
    ring_wdata = {stamp_inc, req_r.frame_type, req_r.msg_len, req_r.handle};
    snap_wdata = ring_wdata;
    ring_raddr = raddr_of(in_si, head_r[in_si]);
    sc = strike_r[si];
    sc_new = sc;
    sum = 9'(sc) + 9'(FAIL_STRIKES);
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        res_nxt = '0;
        res_nxt.slot_out = req_r.slot;
        res_nxt.last = 1'b1;
        state_nxt = S_OUT;
        case (req_r.op)
          OP_OPEN: begin
            if (found) begin
              used_nxt[free_i] = 1'b1;
              closing_nxt[free_i] = 1'b0;
              snap_pend_nxt[free_i] = 1'b0;
              strike_nxt[free_i] = '0;
              head_nxt[free_i] = '0;
              count_nxt[free_i] = '0;
              res_nxt.slot_out = 3'(free_i);
            end else begin
              res_nxt.status = ST_NO_SLOT;
              res_nxt.slot_out = '0;
            end
          end
          OP_ENQ: begin
            res_nxt.freed_valid = 1'b1;
            res_nxt.freed_handle = req_r.handle;
            if (req_r.msg_len == '0) res_nxt.status = ST_BAD_ARG;
            else if (!valid_slot) res_nxt.status = ST_NOT_FOUND;
            else if (closing_r[si]) res_nxt.status = ST_CLOSING;
            else begin
              res_nxt.freed_valid = 1'b0;
              res_nxt.freed_handle = '0;
              if (req_r.coalescible) begin
                if (snap_pend_r[si]) begin
                  res_nxt.freed_valid = 1'b1;
                  res_nxt.freed_handle = snap_rdata[15:0];
                  if (sc < STRIKE_MAX) sc_new = sc + 8'd1;
                end
                snap_we = 1'b1;
                snap_pend_nxt[si] = 1'b1;
                gstamp_nxt = stamp_inc;
              end else if (32'(count_r[si]) < RING_DEPTH) begin
                ring_we = 1'b1;
                count_nxt[si] = count_r[si] + 1'b1;
                gstamp_nxt = stamp_inc;
              end else begin
                sc_new = limit_r;
                res_nxt.status = ST_FULL;
                res_nxt.freed_valid = 1'b1;
                res_nxt.freed_handle = req_r.handle;
              end
              strike_nxt[si] = sc_new;
              if (sc_new >= limit_r) begin
                closing_nxt[si] = 1'b1;
                res_nxt.request_close = 1'b1;
              end
            end
          end
          OP_DEQ: begin
            if (!valid_slot) res_nxt.status = ST_NOT_FOUND;
            else if (count_r[si] != '0 && (!snap_pend_r[si] || ring_older)) begin
              res_nxt.out_handle = ring_rdata[15:0];
              res_nxt.out_len = ring_rdata[31:16];
              res_nxt.out_type = ring_rdata[32];
              head_nxt[si] = RW'((32'(head_r[si]) + 1) % RING_DEPTH);
              count_nxt[si] = count_r[si] - 1'b1;
            end else if (snap_pend_r[si]) begin
              res_nxt.out_handle = snap_rdata[15:0];
              res_nxt.out_len = snap_rdata[31:16];
              res_nxt.out_type = snap_rdata[32];
              snap_pend_nxt[si] = 1'b0;
            end else res_nxt.status = ST_EMPTY;
          end
          OP_OUTC: begin
            if (!valid_slot) res_nxt.status = ST_NOT_FOUND;
            else if (req_r.send_ok) begin
              if (sc >= OK_RELIEF) strike_nxt[si] = sc - OK_RELIEF;
            end else begin
              sc_new = sum[8] ? STRIKE_MAX : sum[7:0];
              strike_nxt[si] = sc_new;
              if (!closing_r[si] && sc_new >= limit_r) begin
                closing_nxt[si] = 1'b1;
                res_nxt.request_close = 1'b1;
              end
            end
          end
          OP_CLOSE: begin
            if (!valid_slot) res_nxt.status = ST_NOT_FOUND;
            else begin
              // hold result; stream ring entries head first, then snapshot
              drain_i_nxt = '0;
              drain_snap_nxt = snap_pend_r[si];
              snap_h_nxt = snap_rdata[15:0];
              ring_raddr = raddr_of(si, head_r[si]);
              state_nxt = S_DRAIN;
              if (count_r[si] == '0 && !snap_pend_r[si]) begin
                state_nxt = S_OUT;
                used_nxt[si] = 1'b0;
                closing_nxt[si] = 1'b0;
                strike_nxt[si] = '0;
                head_nxt[si] = '0;
                count_nxt[si] = '0;
              end
            end
          end
          default: res_nxt.status = ST_BAD_ARG;
        endcase
        if (state_nxt == S_OUT) out_valid_nxt = 1'b1;
      end
      S_DRAIN: begin
        // ring data for drain_i_r is on ring_rdata this cycle
        ring_raddr = raddr_of(si, drain_idx);
        if (!out_valid_r || out_ready) begin
          res_nxt = '0;
          res_nxt.slot_out = req_r.slot;
          res_nxt.freed_valid = 1'b1;
          out_valid_nxt = 1'b1;
          if (drain_i_r < count_r[si]) begin
            res_nxt.freed_handle = ring_rdata[15:0];
            drain_i_nxt = drain_i_r + 1'b1;
            ring_raddr = raddr_of(si, RW'((32'(drain_idx) + 1) % RING_DEPTH));
            res_nxt.last = (drain_i_nxt == count_r[si]) && !drain_snap_r;
          end else begin
            res_nxt.freed_handle = snap_h_r;
            res_nxt.last = 1'b1;
          end
          if (res_nxt.last) begin
            used_nxt[si] = 1'b0;
            closing_nxt[si] = 1'b0;
            snap_pend_nxt[si] = 1'b0;
            strike_nxt[si] = '0;
            head_nxt[si] = '0;
            count_nxt[si] = '0;
            state_nxt = S_OUT;
          end
        end
      end
      S_OUT: begin
        if (!out_valid_nxt) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      limit_r <= 8'd8;
      used_r <= '0;
      closing_r <= '0;
      snap_pend_r <= '0;
      gstamp_r <= '0;
      out_valid_r <= 1'b0;
      drain_i_r <= '0;
      drain_snap_r <= 1'b0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        strike_r[i] <= '0;
        head_r[i] <= '0;
        count_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) limit_r <= cfg_data;
      used_r <= used_nxt;
      closing_r <= closing_nxt;
      snap_pend_r <= snap_pend_nxt;
      gstamp_r <= gstamp_nxt;
      out_valid_r <= out_valid_nxt;
      drain_i_r <= drain_i_nxt;
      drain_snap_r <= drain_snap_nxt;
      strike_r <= strike_nxt;
      head_r <= head_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) req_r <= in_req;
    res_r <= res_nxt;
    snap_h_r <= snap_h_nxt;
  end
endmodule
`default_nettype wire

@@ sim/testbench.sv @@
// Self-checking testbench for egress_queue_with_snapshot_coalescing_top.
// Depends on eqsc_pkg and the block's RTL; drives requests, predicts results.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
  import eqsc_pkg::*;

  typedef struct {
    req_t req;
    bit   fixed;
    res_t res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  req_t in_req = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  res_t out_res;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [7:0] cfg_data = 8'd0;

  // Predicted copy of the block's state and its register
  logic [7:0]  strike_lim;
  bit          used_q [8];
  bit          closing_q [8];
  logic [7:0]  strikes [8];
  logic [2:0]  head_q [8];
  logic [3:0]  count_q [8];
  logic [32:0] ring_d [8][8];
  logic [31:0] ring_s [8][8];
  logic [32:0] snap_d [8];
  logic [31:0] snap_s [8];
  bit          snap_p [8];
  logic [31:0] stamp_ctr;

  res_t pending_res [$];
  int   err_cnt = 0;
  bit   tx_idle_en = 1'b1;
  bit   rx_idle_en = 1'b1;
  bit   rx_hold_req = 1'b0;
  stim_row_t dir_rows [$];

  egress_queue_with_snapshot_coalescing_top i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_req(in_req),
    .out_valid(out_valid), .out_ready(out_ready), .out_res(out_res),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  task automatic clear_slot(int s);
    used_q[s] = 0;
    closing_q[s] = 0;
    strikes[s] = 8'd0;
    head_q[s] = 3'd0;
    count_q[s] = 4'd0;
    snap_p[s] = 0;
  endtask

  // Compute the results one accepted request causes and advance the state
  task automatic queue_step(req_t r, bit fixed, res_t fixed_res);
    res_t o;
    int s;
    int found;
    logic [32:0] d;
    logic [2:0] tail;
    logic [31:0] diff;
    bit ring_first;
    logic [15:0] freed [$];
    s = r.slot;
    d = {r.frame_type, r.msg_len, r.handle};
    o = '0;
    o.slot_out = r.slot;
    o.last = 1'b1;
    case (r.op)
      OP_OPEN: begin
        found = -1;
        for (int i = 0; i < 8; i++) if (found < 0 && !used_q[i]) found = i;
        if (found >= 0) begin
          clear_slot(found);
          used_q[found] = 1;
          o.slot_out = found[2:0];
        end else begin
          o.status = ST_NO_SLOT;
          o.slot_out = 3'd0;
        end
      end
      OP_ENQ: begin
        if (r.msg_len == 16'd0 || !used_q[s] || closing_q[s]) begin
          o.status = (r.msg_len == 16'd0) ? ST_BAD_ARG : (!used_q[s] ? ST_NOT_FOUND : ST_CLOSING);
          o.freed_valid = 1'b1;
          o.freed_handle = r.handle;
        end else begin
          if (r.coalescible) begin
            if (snap_p[s]) begin
              o.freed_valid = 1'b1;
              o.freed_handle = snap_d[s][15:0];
              if (strikes[s] < STRIKE_MAX) strikes[s]++;
            end
            stamp_ctr++;
            snap_d[s] = d;
            snap_s[s] = stamp_ctr;
            snap_p[s] = 1;
          end else if (count_q[s] < 4'd8) begin
            tail = head_q[s] + count_q[s][2:0];
            stamp_ctr++;
            ring_d[s][tail] = d;
            ring_s[s][tail] = stamp_ctr;
            count_q[s]++;
          end else begin
            strikes[s] = strike_lim;
            o.status = ST_FULL;
            o.freed_valid = 1'b1;
            o.freed_handle = r.handle;
          end
          if (strikes[s] >= strike_lim) begin
            closing_q[s] = 1;
            o.request_close = 1'b1;
          end
        end
      end
      OP_DEQ: begin
        if (!used_q[s]) o.status = ST_NOT_FOUND;
        else begin
          diff = ring_s[s][head_q[s]] - snap_s[s];
          ring_first = count_q[s] != 0 && (!snap_p[s] || diff[31]);
          if (ring_first) begin
            d = ring_d[s][head_q[s]];
            head_q[s]++;
            count_q[s]--;
          end else if (snap_p[s]) begin
            d = snap_d[s];
            snap_p[s] = 0;
          end else o.status = ST_EMPTY;
          if (o.status == ST_OK) {o.out_type, o.out_len, o.out_handle} = d;
        end
      end
      OP_OUTC: begin
        if (!used_q[s]) o.status = ST_NOT_FOUND;
        else if (r.send_ok) begin
          if (strikes[s] >= OK_RELIEF) strikes[s] -= OK_RELIEF;
        end else begin
          strikes[s] = (strikes[s] > STRIKE_MAX - FAIL_STRIKES) ? STRIKE_MAX
                                                                : strikes[s] + FAIL_STRIKES;
          if (!closing_q[s] && strikes[s] >= strike_lim) begin
            closing_q[s] = 1;
            o.request_close = 1'b1;
          end
        end
      end
      OP_CLOSE: begin
        if (!used_q[s]) o.status = ST_NOT_FOUND;
        else begin
          for (int i = 0; i < count_q[s]; i++)
            freed.push_back(ring_d[s][head_q[s] + 3'(i)][15:0]);
          if (snap_p[s]) freed.push_back(snap_d[s][15:0]);
          clear_slot(s);
          // drain one freed handle per result, ring head first
          foreach (freed[k]) begin
            o.freed_valid = 1'b1;
            o.freed_handle = freed[k];
            o.last = (k == freed.size() - 1);
            pending_res.push_back(o);
          end
          if (freed.size() > 0) return;
        end
      end
      default: o.status = ST_BAD_ARG;
    endcase
    pending_res.push_back(fixed ? fixed_res : o);
  endtask

  // Offer one request and hold it until the block takes it
  task automatic send_req(req_t r, bit fixed = 0, res_t fixed_res = '0);
    in_valid <= 1'b1;
    in_req <= r;
    do @(posedge clk); while (!in_ready);
    queue_step(r, fixed, fixed_res);
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk);
    // close may still be busy internally; give it time to settle
    repeat (12) @(posedge clk);
  endtask

  task automatic write_limit(logic [7:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    strike_lim = v;
    cfg_valid <= 1'b0;
  endtask

  function automatic req_t rand_req();
    req_t r;
    int pick;
    int used_list [$];
    r.op = OP_ENQ;
    pick = $urandom_range(0, 99);
    if (pick < 8) r.op = OP_OPEN;
    else if (pick < 55) r.op = OP_ENQ;
    else if (pick < 75) r.op = OP_DEQ;
    else if (pick < 90) r.op = OP_OUTC;
    else if (pick < 96) r.op = OP_CLOSE;
    else r.op = 3'($urandom_range(5, 7));
    for (int i = 0; i < 8; i++) if (used_q[i]) used_list.push_back(i);
    r.slot = 3'($urandom_range(0, 7));
    if (used_list.size() != 0 && $urandom_range(0, 9) < 8)
      r.slot = 3'(used_list[$urandom_range(0, used_list.size() - 1)]);
    r.coalescible = $urandom_range(0, 3) == 0;
    r.frame_type = 1'($urandom_range(0, 1));
    r.msg_len = ($urandom_range(0, 19) == 0) ? 16'd0 : 16'($urandom);
    r.handle = 16'($urandom);
    r.send_ok = $urandom_range(0, 2) != 0;
    return r;
  endfunction

  function automatic stim_row_t row(logic [2:0] op, logic [2:0] slot, bit coal, bit ft,
                                    logic [15:0] len, logic [15:0] hnd, bit ok,
                                    bit fixed = 0, res_t res = '0);
    stim_row_t t;
    t.req = '{op, slot, coal, ft, len, hnd, ok};
    t.fixed = fixed;
    t.res = res;
    return t;
  endfunction

  // Compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_res.size() == 0) begin
        $error("unexpected result: %p", out_res);
        err_cnt++;
      end else begin
        res_t e;
        e = pending_res.pop_front();
        if (out_res.status !== e.status) begin
          $error("status exp %0d got %0d", e.status, out_res.status); err_cnt++;
        end
        if (out_res.slot_out !== e.slot_out) begin
          $error("slot_out exp %0d got %0d", e.slot_out, out_res.slot_out); err_cnt++;
        end
        if (out_res.out_handle !== e.out_handle) begin
          $error("out_handle exp %h got %h", e.out_handle, out_res.out_handle); err_cnt++;
        end
        if (out_res.out_len !== e.out_len) begin
          $error("out_len exp %h got %h", e.out_len, out_res.out_len); err_cnt++;
        end
        if (out_res.out_type !== e.out_type) begin
          $error("out_type exp %0d got %0d", e.out_type, out_res.out_type); err_cnt++;
        end
        if (out_res.request_close !== e.request_close) begin
          $error("request_close exp %0d got %0d", e.request_close, out_res.request_close);
          err_cnt++;
        end
        if (out_res.freed_valid !== e.freed_valid) begin
          $error("freed_valid exp %0d got %0d", e.freed_valid, out_res.freed_valid); err_cnt++;
        end
        if (out_res.freed_handle !== e.freed_handle) begin
          $error("freed_handle exp %h got %h", e.freed_handle, out_res.freed_handle); err_cnt++;
        end
        if (out_res.last !== e.last) begin
          $error("last exp %0d got %0d", e.last, out_res.last); err_cnt++;
        end
      end
    end
  end

  // Receiver: random stalls, one long hold-off on demand, none at the end
  initial begin
    forever begin
      if (rx_hold_req) begin
        out_ready <= 1'b0;
        for (int c = 0; c < 300; c++) @(posedge clk);
        rx_hold_req = 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  initial begin
    #5ms;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    logic [7:0] limits [5];
    strike_lim = 8'd8;
    stamp_ctr = '0;
    for (int i = 0; i < 8; i++) clear_slot(i);
    limits = '{8'd8, 8'd1, 8'd255, 8'd0, 8'd0};
    limits[4] = 8'($urandom_range(2, 254));

    // Directed requests: errors on an empty block, then one slot end to end
    dir_rows.push_back(row(OP_DEQ, 3'd0, 0, 0, 16'd5, 16'd5, 0, 1,
                           '{ST_NOT_FOUND, 3'd0, 16'd0, 16'd0, 0, 0, 0, 16'd0, 1}));
    dir_rows.push_back(row(3'd5, 3'd3, 1, 1, 16'hFFFF, 16'hFFFF, 1, 1,
                           '{ST_BAD_ARG, 3'd3, 16'd0, 16'd0, 0, 0, 0, 16'd0, 1}));
    dir_rows.push_back(row(3'd7, 3'd7, 0, 0, 16'd0, 16'd0, 0, 1,
                           '{ST_BAD_ARG, 3'd7, 16'd0, 16'd0, 0, 0, 0, 16'd0, 1}));
    dir_rows.push_back(row(3'd6, 3'd2, 0, 0, 16'd1, 16'd1, 0));
    dir_rows.push_back(row(OP_CLOSE, 3'd4, 0, 0, 16'd1, 16'd1, 0, 1,
                           '{ST_NOT_FOUND, 3'd4, 16'd0, 16'd0, 0, 0, 0, 16'd0, 1}));
    dir_rows.push_back(row(OP_OPEN, 3'd7, 0, 0, 16'd0, 16'd0, 0, 1,
                           '{ST_OK, 3'd0, 16'd0, 16'd0, 0, 0, 0, 16'd0, 1}));
    dir_rows.push_back(row(OP_ENQ, 3'd0, 0, 1, 16'd0, 16'hFFFF, 0, 1,
                           '{ST_BAD_ARG, 3'd0, 16'd0, 16'd0, 0, 0, 1, 16'hFFFF, 1}));
    dir_rows.push_back(row(OP_ENQ, 3'd5, 0, 0, 16'd1, 16'h1234, 0, 1,
                           '{ST_NOT_FOUND, 3'd5, 16'd0, 16'd0, 0, 0, 1, 16'h1234, 1}));
    dir_rows.push_back(row(OP_ENQ, 3'd0, 0, 1, 16'hFFFF, 16'hFFFF, 0));
    dir_rows.push_back(row(OP_ENQ, 3'd0, 1, 0, 16'd1, 16'h0001, 0));
    dir_rows.push_back(row(OP_ENQ, 3'd0, 1, 1, 16'h8000, 16'h0002, 0));
    dir_rows.push_back(row(OP_ENQ, 3'd0, 0, 0, 16'd7, 16'h00A5, 0));
    dir_rows.push_back(row(OP_DEQ, 3'd0, 0, 0, 16'd0, 16'd0, 0));
    dir_rows.push_back(row(OP_DEQ, 3'd0, 0, 0, 16'd0, 16'd0, 0));
    dir_rows.push_back(row(OP_DEQ, 3'd0, 0, 0, 16'd0, 16'd0, 0));
    dir_rows.push_back(row(OP_DEQ, 3'd0, 0, 0, 16'd0, 16'd0, 0, 1,
                           '{ST_EMPTY, 3'd0, 16'd0, 16'd0, 0, 0, 0, 16'd0, 1}));
    dir_rows.push_back(row(OP_OUTC, 3'd0, 0, 0, 16'd0, 16'd0, 0));
    dir_rows.push_back(row(OP_OUTC, 3'd0, 0, 0, 16'd0, 16'd0, 1));
    dir_rows.push_back(row(OP_OUTC, 3'd0, 0, 0, 16'd0, 16'd0, 0));
    dir_rows.push_back(row(OP_ENQ, 3'd0, 0, 0, 16'd3, 16'h0BEE, 0));
    dir_rows.push_back(row(OP_ENQ, 3'd0, 1, 0, 16'd3, 16'h0CAB, 0));
    dir_rows.push_back(row(OP_ENQ, 3'd0, 0, 0, 16'd3, 16'h0DAD, 0));
    dir_rows.push_back(row(OP_CLOSE, 3'd0, 0, 0, 16'd0, 16'd0, 0));
    dir_rows.push_back(row(OP_CLOSE, 3'd0, 0, 0, 16'd0, 16'd0, 0, 1,
                           '{ST_NOT_FOUND, 3'd0, 16'd0, 16'd0, 0, 0, 0, 16'd0, 1}));

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) send_req(dir_rows[i].req, dir_rows[i].fixed, dir_rows[i].res);
    drain_results();

    // Random phases, each under its own strike limit
    for (int p = 0; p < 5; p++) begin
      write_limit(limits[p]);
      if (p == 4) begin
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
      end
      for (int n = 0; n < 50; n++) begin
        // hold the receiver off while requests keep coming, to back up the block
        if (p == 1 && n == 5) rx_hold_req = 1'b1;
        send_req(rand_req());
      end
      drain_results();
    end

    if (err_cnt == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule
`default_nettype wire

@@ filelist.f @@
sv/eqsc_pkg.sv
sv/eqsc_ram.sv
sv/egress_queue_with_snapshot_coalescing_top.sv
sim/testbench.sv
